/* design/firmware_image_verifier_defines.svh */
// Assertion macros shared by the verifier's checker.
// No dependencies; take in with `include before use.
`ifndef FIRMWARE_IMAGE_VERIFIER_DEFINES_SVH
`define FIRMWARE_IMAGE_VERIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define FIV_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define FIV_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/fiv_pkg.sv */
// Constants, status codes and the CRC-32 byte update for the firmware image verifier.
// No dependencies.
package fiv_pkg;

    localparam int unsigned CNT_W = 27;

    localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] HDR_LEN     = 27'd40;
    localparam logic [31:0]      HDR_MAGIC   = 32'h4d4c4657;
    localparam logic [15:0]      HDR_FORMAT  = 16'd1;
    localparam logic [15:0]      HDR_SIZE    = 16'd40;
    localparam logic [31:0]      CRC_POLY    = 32'hEDB88320;
    localparam logic [31:0]      CRC_INIT    = 32'hFFFFFFFF;
    localparam logic [63:0]      MAX_IMAGE_BYTES = 64'd67108864;

    // Result status codes
    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_BAD_HDR   = 3'd1;
    localparam logic [2:0] ST_SIZE_BAD  = 3'd2;
    localparam logic [2:0] ST_CRC_BAD   = 3'd3;
    localparam logic [2:0] ST_ROLLBACK  = 3'd4;

    // Register indexes (byte address 4*i)
    localparam logic [1:0] REG_CUR_MAJOR = 2'd0;
    localparam logic [1:0] REG_CUR_MINOR = 2'd1;
    localparam logic [1:0] REG_CUR_PATCH = 2'd2;
    localparam logic [1:0] REG_ALLOW_DG  = 2'd3;

    // Reflected CRC-32, one byte, bit at a time
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

/* design/firmware_image_verifier.sv */
// Firmware image verifier top level: header parse, payload CRC-32, result register.
// Depends on fiv_pkg.
//
//  channel   dir  ports                          moves
//  s_        in   s_valid/s_ready                one file byte + last flag
//  m_        out  m_valid/m_ready                one verdict per file
//  apb       in   psel/penable/pwrite/paddr      installed version, downgrade
//
// Cycles: one byte per clock while s_ready is high; the CRC byte update and
// header capture sit in one stage between the file state and result registers.
// The verdict is registered on the clock that accepts the last byte.
// Reset: synchronous, active low; clears file state, registers and m_valid.
// Stalls: s_ready drops only while a verdict waits and m_ready is low.
module firmware_image_verifier
    import fiv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic        m_header_ok,
    output logic        m_size_ok,
    output logic        m_crc_ok,
    output logic        m_accepted,
    output logic [15:0] m_arch_code,
    output logic [15:0] m_image_major,
    output logic [15:0] m_image_minor,
    output logic [15:0] m_image_patch,
    output logic [63:0] m_payload_size,
    output logic [31:0] m_stored_crc,
    output logic [31:0] m_computed_crc
);

    // configuration registers
    logic [15:0] cur_major_reg, cur_minor_reg, cur_patch_reg;
    logic        allow_dg_reg;

    // per-file state
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             hdr_good_reg, hdr_good_next;
    logic [15:0]      arch_reg, arch_next;
    logic [15:0]      major_reg, major_next;
    logic [15:0]      minor_reg, minor_next;
    logic [15:0]      patch_reg, patch_next;
    logic [63:0]      size_reg, size_next;
    logic [31:0]      crcw_reg, crcw_next;
    logic [31:0]      crc_reg, crc_next;

    // result register
    logic        m_valid_reg;
    logic [2:0]  status_reg;
    logic        hok_reg, sok_reg, cok_reg, acc_reg;
    logic [15:0] arch_out_reg, major_out_reg, minor_out_reg, patch_out_reg;
    logic [63:0] size_out_reg;
    logic [31:0] crcw_out_reg, crc_out_reg;

    logic        in_fire, wr_fire, in_hdr;
    logic [5:0]  idx;
    logic        chk_en;
    logic [7:0]  chk_byte;
    logic        hok, sok, cok, acc, newer;
    logic [31:0] crc_final;
    logic [2:0]  status;

    assign pready  = 1'b1;
    assign wr_fire = psel & penable & pwrite;
    assign s_ready = ~m_valid_reg | m_ready;
    assign in_fire = s_valid & s_ready;
    assign in_hdr  = cnt_reg < HDR_LEN;
    assign idx     = cnt_reg[5:0];

    always_comb begin
        unique case (paddr[3:2])
            REG_CUR_MAJOR: prdata = {16'd0, cur_major_reg};
            REG_CUR_MINOR: prdata = {16'd0, cur_minor_reg};
            REG_CUR_PATCH: prdata = {16'd0, cur_patch_reg};
            REG_ALLOW_DG:  prdata = {31'd0, allow_dg_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // fixed header bytes to check
    always_comb begin
        chk_en   = 1'b0;
        chk_byte = 8'd0;
        if (in_hdr) begin
            if (idx < 6'd4) begin
                chk_en   = 1'b1;
                chk_byte = HDR_MAGIC[{idx[1:0], 3'b000} +: 8];
            end else if (idx < 6'd6) begin
                chk_en   = 1'b1;
                chk_byte = HDR_FORMAT[{idx[0], 3'b000} +: 8];
            end else if (idx == 6'd14 || idx == 6'd15) begin
                chk_en   = 1'b1;
                chk_byte = HDR_SIZE[{idx[0], 3'b000} +: 8];
            end
        end
    end

    always_comb begin
        cnt_next      = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
        hdr_good_next = hdr_good_reg & ~(chk_en & (s_data_byte != chk_byte));
        arch_next     = arch_reg;
        major_next    = major_reg;
        minor_next    = minor_reg;
        patch_next    = patch_reg;
        size_next     = size_reg;
        crcw_next     = crcw_reg;
        crc_next      = crc_reg;
        if (in_hdr) begin
            if (idx == 6'd6 || idx == 6'd7) begin
                arch_next[{idx[0], 3'b000} +: 8] = s_data_byte;
            end else if (idx == 6'd8 || idx == 6'd9) begin
                major_next[{idx[0], 3'b000} +: 8] = s_data_byte;
            end else if (idx == 6'd10 || idx == 6'd11) begin
                minor_next[{idx[0], 3'b000} +: 8] = s_data_byte;
            end else if (idx == 6'd12 || idx == 6'd13) begin
                patch_next[{idx[0], 3'b000} +: 8] = s_data_byte;
            end else if (idx >= 6'd16 && idx < 6'd24) begin
                size_next[{idx[2:0], 3'b000} +: 8] = s_data_byte;
            end else if (idx >= 6'd24 && idx < 6'd28) begin
                crcw_next[{idx[1:0], 3'b000} +: 8] = s_data_byte;
            end
        end else begin
            crc_next = crc32_byte(crc_reg, s_data_byte);
        end
    end

    // verdict on the state as it stands after this byte
    always_comb begin
        crc_final = ~crc_next;
        hok   = hdr_good_next & (cnt_next >= HDR_LEN);
        sok   = (cnt_next != CNT_MAX) &&
                ({{(64-CNT_W){1'b0}}, cnt_next - HDR_LEN} == size_next);
        cok   = sok && (size_next <= MAX_IMAGE_BYTES) && (crc_final == crcw_next);
        newer = {major_next, minor_next, patch_next} >
                {cur_major_reg, cur_minor_reg, cur_patch_reg};
        acc   = cok & (allow_dg_reg | newer);
        priority if (!hok) status = ST_BAD_HDR;
        else if (!sok)     status = ST_SIZE_BAD;
        else if (!cok)     status = ST_CRC_BAD;
        else if (!acc)     status = ST_ROLLBACK;
        else               status = ST_ACCEPTED;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_major_reg <= 16'd0;
            cur_minor_reg <= 16'd0;
            cur_patch_reg <= 16'd0;
            allow_dg_reg  <= 1'b0;
        end else if (wr_fire) begin
            unique case (paddr[3:2])
                REG_CUR_MAJOR: cur_major_reg <= pwdata[15:0];
                REG_CUR_MINOR: cur_minor_reg <= pwdata[15:0];
                REG_CUR_PATCH: cur_patch_reg <= pwdata[15:0];
                REG_ALLOW_DG:  allow_dg_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (in_fire && s_last_byte)) begin
            // start over for the next file
            cnt_reg      <= '0;
            hdr_good_reg <= 1'b1;
            arch_reg     <= 16'd0;
            major_reg    <= 16'd0;
            minor_reg    <= 16'd0;
            patch_reg    <= 16'd0;
            size_reg     <= 64'd0;
            crcw_reg     <= 32'd0;
            crc_reg      <= CRC_INIT;
        end else if (in_fire) begin
            cnt_reg      <= cnt_next;
            hdr_good_reg <= hdr_good_next;
            arch_reg     <= arch_next;
            major_reg    <= major_next;
            minor_reg    <= minor_next;
            patch_reg    <= patch_next;
            size_reg     <= size_next;
            crcw_reg     <= crcw_next;
            crc_reg      <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_fire && s_last_byte) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && s_last_byte) begin
            status_reg    <= status;
            hok_reg       <= hok;
            sok_reg       <= hok & sok;
            cok_reg       <= hok & cok;
            acc_reg       <= hok & acc;
            // a bad header zeroes every field
            arch_out_reg  <= hok ? arch_next  : 16'd0;
            major_out_reg <= hok ? major_next : 16'd0;
            minor_out_reg <= hok ? minor_next : 16'd0;
            patch_out_reg <= hok ? patch_next : 16'd0;
            size_out_reg  <= hok ? size_next  : 64'd0;
            crcw_out_reg  <= hok ? crcw_next  : 32'd0;
            crc_out_reg   <= hok ? crc_final  : 32'd0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_header_ok    = hok_reg;
    assign m_size_ok      = sok_reg;
    assign m_crc_ok       = cok_reg;
    assign m_accepted     = acc_reg;
    assign m_arch_code    = arch_out_reg;
    assign m_image_major  = major_out_reg;
    assign m_image_minor  = minor_out_reg;
    assign m_image_patch  = patch_out_reg;
    assign m_payload_size = size_out_reg;
    assign m_stored_crc   = crcw_out_reg;
    assign m_computed_crc = crc_out_reg;

endmodule

/* design/fiv_checker.sv */
// Port-level checker for the firmware image verifier, bound to the top level.
// Depends on fiv_pkg and firmware_image_verifier_defines.svh.
`include "firmware_image_verifier_defines.svh"

module fiv_checker
    import fiv_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_last_byte,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic        m_header_ok,
    input logic        m_size_ok,
    input logic        m_crc_ok,
    input logic        m_accepted,
    input logic [63:0] m_payload_size,
    input logic [31:0] m_stored_crc,
    input logic [31:0] m_computed_crc
);

    `FIV_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status), "verdict dropped or changed while stalled")

    `FIV_ASSERT_NOW(a_rise_after_last, aclk, aresetn, $rose(m_valid), $past(s_valid && s_ready && s_last_byte), "verdict without a last item")

    `FIV_ASSERT_NOW(a_accept_flags, aclk, aresetn, m_valid && (m_status == ST_ACCEPTED), m_accepted && m_crc_ok && m_size_ok && m_header_ok, "accepted status with a failed check")

    `FIV_ASSERT_NOW(a_bad_hdr_zero, aclk, aresetn, m_valid && (m_status == ST_BAD_HDR), !m_header_ok && !m_size_ok && (m_payload_size == 64'd0) && (m_computed_crc == 32'd0), "bad header verdict carries fields")

    `FIV_ASSERT_NOW(a_crc_match, aclk, aresetn, m_valid && m_crc_ok, m_size_ok && (m_computed_crc == m_stored_crc), "crc_ok without matching CRC")

endmodule

bind firmware_image_verifier fiv_checker u_fiv_checker (.*);

/* tb/firmware_image_verifier_test.sv */
// Self-checking testbench for firmware_image_verifier: streams whole image files byte by byte,
// predicts each verdict on its own and compares it field by field with the result channel.
// Depends on fiv_pkg and the firmware_image_verifier module.
module firmware_image_verifier_test;
    import fiv_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic        header_ok;
        logic        size_ok;
        logic        crc_ok;
        logic        accepted;
        logic [15:0] arch;
        logic [15:0] major;
        logic [15:0] minor;
        logic [15:0] patch;
        logic [63:0] payload_size;
        logic [31:0] stored_crc;
        logic [31:0] computed_crc;
    } verdict_t;

    // One image file to send; arch and all random content are drawn when it is queued.
    typedef struct packed {
        logic [15:0] major;
        logic [15:0] minor;
        logic [15:0] patch;
        logic [7:0]  payload_len;
        logic [7:0]  cut_len;      // nonzero: the file ends after this many bytes
        logic [7:0]  spoil_at;     // header byte to corrupt, or NO_SPOIL
        logic        size_forced;
        logic [63:0] size_word;
        logic        crc_flip;
        logic        typed;        // status below is fixed by hand
        logic [2:0]  status;
    } image_spec_t;

    typedef struct packed {
        logic       typed;
        logic [2:0] status;
    } status_claim_t;

    localparam logic [7:0]  NO_SPOIL        = 8'hFF;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned STUCK_LIMIT     = 4000;
    localparam int unsigned PHASE_BYTES     = 170;
    localparam int unsigned N_PHASES        = 6;
    localparam int          N_DIRECTED      = 16;

    // Installed version after reset is 0.0.0 with downgrade off.
    localparam image_spec_t DIRECTED_IMAGES [N_DIRECTED] = '{
        // major    minor     patch     len    cut    spoil     frc  size word  flip typed
        '{16'h0000, 16'h0000, 16'h0000, 8'd0,  8'd1,  NO_SPOIL, 1'b0, 64'd0, 1'b0, 1'b1, ST_BAD_HDR},
        '{16'h0000, 16'h0000, 16'h0001, 8'd0,  8'd39, NO_SPOIL, 1'b0, 64'd0, 1'b0, 1'b1, ST_BAD_HDR},
        '{16'h0000, 16'h0000, 16'h0001, 8'd2,  8'd0,  8'd0,     1'b0, 64'd0, 1'b0, 1'b1, ST_BAD_HDR},
        '{16'h0000, 16'h0000, 16'h0001, 8'd2,  8'd0,  8'd3,     1'b0, 64'd0, 1'b0, 1'b1, ST_BAD_HDR},
        '{16'h0000, 16'h0000, 16'h0001, 8'd0,  8'd0,  8'd4,     1'b0, 64'd0, 1'b0, 1'b1, ST_BAD_HDR},
        '{16'h0000, 16'h0000, 16'h0001, 8'd0,  8'd0,  8'd5,     1'b0, 64'd0, 1'b0, 1'b1, ST_BAD_HDR},
        '{16'h0000, 16'h0000, 16'h0001, 8'd1,  8'd0,  8'd14,    1'b0, 64'd0, 1'b0, 1'b1, ST_BAD_HDR},
        '{16'h0000, 16'h0000, 16'h0001, 8'd1,  8'd0,  8'd15,    1'b0, 64'd0, 1'b0, 1'b1, ST_BAD_HDR},
        '{16'h0000, 16'h0000, 16'h0000, 8'd0,  8'd0,  NO_SPOIL, 1'b0, 64'd0, 1'b0, 1'b1, ST_ROLLBACK},
        '{16'h0000, 16'h0000, 16'h0001, 8'd0,  8'd0,  NO_SPOIL, 1'b0, 64'd0, 1'b0, 1'b1, ST_ACCEPTED},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd24, 8'd0,  NO_SPOIL, 1'b0, 64'd0, 1'b0, 1'b1, ST_ACCEPTED},
        '{16'h0001, 16'h0000, 16'h0000, 8'd8,  8'd0,  NO_SPOIL, 1'b0, 64'd0, 1'b1, 1'b1, ST_CRC_BAD},
        '{16'h0000, 16'h0001, 16'h0000, 8'd6,  8'd0,  NO_SPOIL, 1'b1, '1,    1'b0, 1'b1, ST_SIZE_BAD},
        '{16'h0000, 16'h0000, 16'h0002, 8'd4,  8'd0,  NO_SPOIL, 1'b1, MAX_IMAGE_BYTES + 64'd1,
          1'b0, 1'b1, ST_SIZE_BAD},
        '{16'h0002, 16'h0000, 16'h0000, 8'd3,  8'd41, NO_SPOIL, 1'b0, 64'd0, 1'b0, 1'b1, ST_SIZE_BAD},
        '{16'h0000, 16'h0002, 16'h0000, 8'd16, 8'd0,  8'd30,    1'b0, 64'd0, 1'b0, 1'b0, ST_ACCEPTED}
    };

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic        m_header_ok;
    logic        m_size_ok;
    logic        m_crc_ok;
    logic        m_accepted;
    logic [15:0] m_arch_code;
    logic [15:0] m_image_major;
    logic [15:0] m_image_minor;
    logic [15:0] m_image_patch;
    logic [63:0] m_payload_size;
    logic [31:0] m_stored_crc;
    logic [31:0] m_computed_crc;

    firmware_image_verifier uut (.*);

    // Predictor copy of the installed version and of the per-file state
    logic [15:0]      inst_major = '0;
    logic [15:0]      inst_minor = '0;
    logic [15:0]      inst_patch = '0;
    logic             inst_allow = 1'b0;
    logic [CNT_W-1:0] rx_count = '0;
    logic [319:0]     hdr_seen = '0;
    logic [31:0]      body_crc = CRC_INIT;

    logic [8:0]    file_bytes [$];       // {last, data}
    verdict_t      pending_verdicts [$];
    status_claim_t status_claims [$];
    int unsigned   bytes_queued = 0;
    int unsigned   bytes_taken = 0;
    int unsigned   mismatches = 0;
    int unsigned   verdicts_checked = 0;
    int unsigned   status_seen [5];
    bit            steady = 1'b0;
    bit            hold_off_request = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [31:0] crc32_next(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        int          i;
        c = crc;
        for (i = 0; i < 8; i++) begin
            c = (c[0] ^ b[i]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Advance the predictor by one byte; returns 1 with the verdict on the last byte.
    function automatic bit predict_byte(input logic [7:0] b, input logic last,
                                        output verdict_t v);
        logic [63:0] body_len;
        logic        newer;
        v = '0;
        if (rx_count < HDR_LEN) begin
            hdr_seen[8*rx_count +: 8] = b;
        end else begin
            body_crc = crc32_next(body_crc, b);
        end
        if (rx_count != CNT_MAX) begin
            rx_count = rx_count + 1'b1;
        end
        if (!last) begin
            return 1'b0;
        end
        if (rx_count >= HDR_LEN && hdr_seen[31:0] == HDR_MAGIC &&
            hdr_seen[47:32] == HDR_FORMAT && hdr_seen[127:112] == HDR_SIZE) begin
            v.header_ok    = 1'b1;
            v.arch         = hdr_seen[63:48];
            v.major        = hdr_seen[79:64];
            v.minor        = hdr_seen[95:80];
            v.patch        = hdr_seen[111:96];
            v.payload_size = hdr_seen[191:128];
            v.stored_crc   = hdr_seen[223:192];
            v.computed_crc = ~body_crc;
            body_len  = 64'(rx_count) - 64'(HDR_LEN);
            v.size_ok = (rx_count != CNT_MAX) && (body_len == v.payload_size);
            v.crc_ok  = v.size_ok && (v.payload_size <= MAX_IMAGE_BYTES) &&
                        (v.computed_crc == v.stored_crc);
            newer = {v.major, v.minor, v.patch} > {inst_major, inst_minor, inst_patch};
            v.accepted = v.crc_ok && (inst_allow || newer);
            if (!v.size_ok) begin
                v.status = ST_SIZE_BAD;
            end else if (!v.crc_ok) begin
                v.status = ST_CRC_BAD;
            end else if (!v.accepted) begin
                v.status = ST_ROLLBACK;
            end else begin
                v.status = ST_ACCEPTED;
            end
        end else begin
            v.status = ST_BAD_HDR;
        end
        rx_count = '0;
        body_crc = CRC_INIT;
        return 1'b1;
    endfunction

    // Build the file's bytes and queue them for the sender.
    function automatic void queue_image(input image_spec_t img);
        logic [319:0] hdr_bits;
        logic [7:0]   body [$];
        logic [7:0]   b;
        logic [31:0]  crc;
        logic [31:0]  stored;
        logic [63:0]  size_word;
        int unsigned  total;
        int unsigned  i;
        crc = CRC_INIT;
        for (i = 0; i < img.payload_len; i++) begin
            b = 8'($urandom);
            body.push_back(b);
            crc = crc32_next(crc, b);
        end
        stored = ~crc;
        if (img.crc_flip) begin
            stored = stored ^ (32'($urandom) | 32'h1);
        end
        size_word = img.size_forced ? img.size_word : 64'(img.payload_len);
        hdr_bits = {$urandom, $urandom, $urandom, stored, size_word, HDR_SIZE, img.patch,
                    img.minor, img.major, 16'($urandom), HDR_FORMAT, HDR_MAGIC};
        if (img.spoil_at != NO_SPOIL) begin
            hdr_bits[8*img.spoil_at +: 8] = hdr_bits[8*img.spoil_at +: 8] ^
                                            8'($urandom_range(1, 255));
        end
        total = (img.cut_len != 0) ? img.cut_len : 40 + img.payload_len;
        for (i = 0; i < total; i++) begin
            b = (i < 40) ? hdr_bits[8*i +: 8] : body[i-40];
            file_bytes.push_back({i == total - 1, b});
        end
        bytes_queued += total;
        status_claims.push_back({img.typed, img.status});
    endfunction

    function automatic logic [15:0] near_value(input logic [15:0] v);
        return v + 16'($urandom_range(2)) - 16'd1;
    endfunction

    // Mostly well-formed files with versions near the installed one, the rest broken.
    function automatic image_spec_t random_image();
        image_spec_t img;
        int unsigned pick;
        img = '0;
        img.spoil_at = NO_SPOIL;
        img.payload_len = ($urandom_range(19) == 0) ? 8'($urandom_range(80, 200)) :
                                                      8'($urandom_range(0, 20));
        case ($urandom_range(3))
            0: begin
                img.major = 16'($urandom);
                img.minor = 16'($urandom);
                img.patch = 16'($urandom);
            end
            1: begin
                img.major = near_value(inst_major);
                img.minor = 16'($urandom);
                img.patch = 16'($urandom);
            end
            2: begin
                img.major = inst_major;
                img.minor = near_value(inst_minor);
                img.patch = 16'($urandom);
            end
            default: begin
                img.major = inst_major;
                img.minor = inst_minor;
                img.patch = near_value(inst_patch);
            end
        endcase
        pick = $urandom_range(99);
        if (pick < 10) begin
            img.crc_flip = 1'b1;
        end else if (pick < 20) begin
            img.size_forced = 1'b1;
            case ($urandom_range(3))
                0: img.size_word = {$urandom, $urandom};
                1: img.size_word = 64'(img.payload_len) + 64'd1;
                2: img.size_word = 64'(img.payload_len) - 64'd1;
                default: img.size_word = '1;
            endcase
        end else if (pick < 28) begin
            // hit one of the fixed words: magic, format or header size
            img.spoil_at = 8'($urandom_range(0, 7));
            if (img.spoil_at >= 6) begin
                img.spoil_at = img.spoil_at + 8'd8;
            end
        end else if (pick < 34) begin
            img.spoil_at = 8'($urandom_range(0, 39));
        end else if (pick < 42) begin
            img.cut_len = 8'($urandom_range(1, 40 + img.payload_len));
        end
        return img;
    endfunction

    function automatic bit take_break();
        return !steady && ($urandom_range(99) < 25);
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatches++;
        if (mismatches <= 100) begin
            $display("mismatch at verdict %0d: %s got %h want %h", verdicts_checked, what,
                     got, want);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        logic [15:0] got;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= (idx == REG_ALLOW_DG) ? {31'($urandom), value[0]} :
                                           {16'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_CUR_MAJOR: inst_major = value;
            REG_CUR_MINOR: inst_minor = value;
            REG_CUR_PATCH: inst_patch = value;
            default:       inst_allow = value[0];
        endcase
        // read it back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = (idx == REG_ALLOW_DG) ? {15'd0, prdata[0]} : prdata[15:0];
        if (got !== ((idx == REG_ALLOW_DG) ? {15'd0, value[0]} : value)) begin
            flag_mismatch("register readback", 64'(got), 64'(value));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_drained(input int unsigned tail);
        do @(posedge aclk);
        while (bytes_taken != bytes_queued || pending_verdicts.size() != 0);
        repeat (tail) @(posedge aclk);
    endtask

    initial begin : byte_source
        logic [8:0] next_byte;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            // hold an item that has not been taken yet
            if (!(s_valid && !s_ready)) begin
                if (file_bytes.size() != 0 && !take_break()) begin
                    next_byte = file_bytes.pop_front();
                    s_valid     <= 1'b1;
                    s_data_byte <= next_byte[7:0];
                    s_last_byte <= next_byte[8];
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    initial begin : verdict_sink
        int unsigned hold_left;
        hold_left = 0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !take_break();
            end
        end
    end

    always @(posedge aclk) begin : observe
        verdict_t      predicted;
        verdict_t      oldest;
        status_claim_t claim;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                bytes_taken++;
                if (predict_byte(s_data_byte, s_last_byte, predicted)) begin
                    claim = status_claims.pop_front();
                    if (claim.typed) begin
                        if (claim.status == ST_BAD_HDR) begin
                            predicted = '0;
                        end
                        predicted.status = claim.status;
                    end
                    pending_verdicts.push_back(predicted);
                    status_seen[predicted.status]++;
                end
            end
            if (m_valid && m_ready) begin
                if (pending_verdicts.size() == 0) begin
                    flag_mismatch("verdict with none expected", 64'(m_status), 64'd0);
                end else begin
                    oldest = pending_verdicts.pop_front();
                    if (m_status !== oldest.status)
                        flag_mismatch("status", 64'(m_status), 64'(oldest.status));
                    if (m_header_ok !== oldest.header_ok)
                        flag_mismatch("header_ok", 64'(m_header_ok), 64'(oldest.header_ok));
                    if (m_size_ok !== oldest.size_ok)
                        flag_mismatch("size_ok", 64'(m_size_ok), 64'(oldest.size_ok));
                    if (m_crc_ok !== oldest.crc_ok)
                        flag_mismatch("crc_ok", 64'(m_crc_ok), 64'(oldest.crc_ok));
                    if (m_accepted !== oldest.accepted)
                        flag_mismatch("accepted", 64'(m_accepted), 64'(oldest.accepted));
                    if (m_arch_code !== oldest.arch)
                        flag_mismatch("arch_code", 64'(m_arch_code), 64'(oldest.arch));
                    if (m_image_major !== oldest.major)
                        flag_mismatch("image_major", 64'(m_image_major), 64'(oldest.major));
                    if (m_image_minor !== oldest.minor)
                        flag_mismatch("image_minor", 64'(m_image_minor), 64'(oldest.minor));
                    if (m_image_patch !== oldest.patch)
                        flag_mismatch("image_patch", 64'(m_image_patch), 64'(oldest.patch));
                    if (m_payload_size !== oldest.payload_size)
                        flag_mismatch("payload_size", m_payload_size, oldest.payload_size);
                    if (m_stored_crc !== oldest.stored_crc)
                        flag_mismatch("stored_crc", 64'(m_stored_crc), 64'(oldest.stored_crc));
                    if (m_computed_crc !== oldest.computed_crc)
                        flag_mismatch("computed_crc", 64'(m_computed_crc),
                                      64'(oldest.computed_crc));
                end
                verdicts_checked++;
            end
        end
    end

    initial begin : watchdog
        int unsigned stuck;
        stuck = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
                stuck = 0;
            end else begin
                stuck++;
            end
            if (stuck >= STUCK_LIMIT) begin
                $display("timeout: nothing moved for %0d cycles", STUCK_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin : main_flow
        int unsigned phase;
        int unsigned row;
        int unsigned phase_end;
        logic [15:0] set_major;
        logic [15:0] set_minor;
        logic [15:0] set_patch;
        logic        set_allow;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (row = 0; row < N_DIRECTED; row++) begin
            queue_image(DIRECTED_IMAGES[row]);
        end
        wait_drained(4);

        for (phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0, 1: begin
                    set_major = '1;
                    set_minor = '1;
                    set_patch = '1;
                    set_allow = (phase == 1);
                end
                3: begin
                    set_major = '0;
                    set_minor = '0;
                    set_patch = '0;
                    set_allow = 1'b0;
                end
                default: begin
                    set_major = 16'($urandom);
                    set_minor = 16'($urandom);
                    set_patch = 16'($urandom);
                    set_allow = (phase == 4);
                end
            endcase
            write_reg(REG_CUR_MAJOR, set_major);
            write_reg(REG_CUR_MINOR, set_minor);
            write_reg(REG_CUR_PATCH, set_patch);
            write_reg(REG_ALLOW_DG, {15'd0, set_allow});
            steady = (phase == 3);
            // stall the result side while the sender keeps pushing bytes
            if (phase == 2) begin
                hold_off_request = 1'b1;
            end
            phase_end = bytes_queued + PHASE_BYTES;
            while (bytes_queued < phase_end) begin
                queue_image(random_image());
            end
            wait_drained(4);
        end
        wait_drained(10);

        $display("ran %0d files (%0d bytes) under %0d version settings, with a long result stall",
                 verdicts_checked, bytes_taken, N_PHASES + 1);
        $display("verdicts: %0d accepted, %0d bad header, %0d size, %0d crc, %0d rollback",
                 status_seen[ST_ACCEPTED], status_seen[ST_BAD_HDR], status_seen[ST_SIZE_BAD],
                 status_seen[ST_CRC_BAD], status_seen[ST_ROLLBACK]);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
